FILE: sv/diamond_window_fetch_top_assert.svh
// assertion macros of the window fetch rtl
`ifndef DIAMOND_WINDOW_FETCH_TOP_ASSERT_SVH
`define DIAMOND_WINDOW_FETCH_TOP_ASSERT_SVH

// clocked check, masked while reset is low
`define DWF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define DWF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/dwf_pkg.sv
// shared types and constants of the window fetch block
`default_nettype none

package dwf_pkg;

  localparam int unsigned DEF_MAX_COLS   = 64;
  localparam int unsigned DEF_MAX_ROWS   = 64;
  localparam int unsigned DEF_VALUE_BITS = 8;
  localparam int unsigned DEF_MAX_RADIUS = 3;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned SIZE_W     = 7;
  localparam int unsigned POS_W      = 6;
  localparam int unsigned CELL_W     = 8;
  localparam int unsigned RAD_W      = 2;
  localparam int unsigned OUT_W      = 9;
  // signed compare width, covers position plus offset and grid limits up to 2047
  localparam int unsigned CMP_W      = 12;
  localparam int unsigned DELTA_W    = 3;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);
  // -1 in the signed result field
  localparam logic [OUT_W-1:0]  OFF_VALUE  = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_HEIGHT = 2'd1
  } cfg_idx_e;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_QUERY = 1'b1
  } req_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } seq_state_e;

  typedef struct packed {
    logic off;
    logic last;
  } rd_tag_t;

  typedef struct packed {
    logic    issue;
    rd_tag_t tag;
  } rd_req_t;

endpackage

`default_nettype wire

FILE: sv/dwf_if.sv
// request, result and register write channels of the window fetch block
`default_nettype none

interface dwf_in_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [dwf_pkg::POS_W-1:0]   pos_x;
  logic [dwf_pkg::POS_W-1:0]   pos_y;
  logic [dwf_pkg::CELL_W-1:0]  cell_value;
  logic [dwf_pkg::RAD_W-1:0]   radius;

  modport source (output valid, output req_type, output pos_x, output pos_y,
                  output cell_value, output radius, input ready);
  modport sink   (input valid, input req_type, input pos_x, input pos_y,
                  input cell_value, input radius, output ready);
endinterface

interface dwf_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [dwf_pkg::OUT_W-1:0]  window_value;
  logic                              is_last;

  modport source (output valid, output window_value, output is_last, input ready);
  modport sink   (input valid, input window_value, input is_last, output ready);
endinterface

interface dwf_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [dwf_pkg::CFG_IDX_W-1:0]     index;
  logic [dwf_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/dwf_ram.sv
// generic single write, single read ram with registered read data
`default_nettype none

module dwf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: sv/dwf_seq.sv
// request sequencer: window walk and shared coordinate unit
`default_nettype none
`include "diamond_window_fetch_top_assert.svh"

module dwf_seq #(
  parameter int unsigned MAX_COLS   = dwf_pkg::DEF_MAX_COLS,
  parameter int unsigned MAX_ROWS   = dwf_pkg::DEF_MAX_ROWS,
  parameter int unsigned VALUE_BITS = dwf_pkg::DEF_VALUE_BITS,
  parameter int unsigned MAX_RADIUS = dwf_pkg::DEF_MAX_RADIUS,
  localparam int unsigned CB        = $clog2(MAX_COLS),
  localparam int unsigned RB        = $clog2(MAX_ROWS),
  localparam int unsigned AW        = CB + RB
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  dwf_in_if.sink                                  in_i,
  input  wire logic signed [dwf_pkg::CMP_W-1:0]   cols_i,
  input  wire logic signed [dwf_pkg::CMP_W-1:0]   rows_i,
  input  wire logic                               issue_ok_i,
  output dwf_pkg::rd_req_t                        rd_o,
  output logic                                    we_o,
  output logic [AW-1:0]                           addr_o,
  output logic [VALUE_BITS-1:0]                   wdata_o
);

  localparam int unsigned CMP_W   = dwf_pkg::CMP_W;
  localparam int unsigned DELTA_W = dwf_pkg::DELTA_W;
  localparam int unsigned POS_W   = dwf_pkg::POS_W;
  localparam int unsigned RAD_W   = dwf_pkg::RAD_W;

  dwf_pkg::seq_state_e state_q, state_d;
  logic [POS_W-1:0]          px_q, px_d, py_q, py_d;
  logic [RAD_W-1:0]          r_q, r_d;
  logic signed [DELTA_W-1:0] dx_q, dx_d, dy_q, dy_d;

  logic                      accept;
  logic                      run;
  logic [RAD_W-1:0]          r_clamp;
  logic signed [DELTA_W-1:0] r_in_s;
  logic signed [DELTA_W-1:0] r_s;
  logic [POS_W-1:0]          base_x, base_y;
  logic signed [DELTA_W-1:0] off_x, off_y;
  logic signed [CMP_W-1:0]   cx, cy;
  logic                      in_grid;
  logic [DELTA_W-1:0]        adx, ady, md_sum;
  logic                      at_last;

  assign run      = (state_q == dwf_pkg::ST_RUN);
  assign in_i.ready = (state_q == dwf_pkg::ST_IDLE);
  assign accept   = in_i.valid && in_i.ready;

  assign r_clamp = (int'(in_i.radius) > int'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : in_i.radius;
  assign r_in_s  = DELTA_W'({1'b0, r_clamp});
  assign r_s     = DELTA_W'({1'b0, r_q});

  // shared coordinate unit: write position when idle, window cell when running
  assign base_x = run ? px_q : in_i.pos_x;
  assign base_y = run ? py_q : in_i.pos_y;
  assign off_x  = run ? dx_q : '0;
  assign off_y  = run ? dy_q : '0;
  assign cx     = CMP_W'(base_x) + CMP_W'(off_x);
  assign cy     = CMP_W'(base_y) + CMP_W'(off_y);
  assign in_grid = !cx[CMP_W-1] && (cx < cols_i) && !cy[CMP_W-1] && (cy < rows_i);
  assign addr_o  = {CB'(cx), RB'(cy)};

  assign adx    = dx_q[DELTA_W-1] ? DELTA_W'(-dx_q) : DELTA_W'(dx_q);
  assign ady    = dy_q[DELTA_W-1] ? DELTA_W'(-dy_q) : DELTA_W'(dy_q);
  assign md_sum = adx + ady;

  assign at_last = (dx_q == r_s) && (dy_q == r_s);

  assign we_o    = accept && (in_i.req_type == dwf_pkg::REQ_WRITE) && in_grid;
  assign wdata_o = VALUE_BITS'(in_i.cell_value);

  assign rd_o.issue    = run && issue_ok_i;
  assign rd_o.tag.off  = !(in_grid && (md_sum <= DELTA_W'({1'b0, r_q})));
  assign rd_o.tag.last = at_last;

  always_comb begin
    state_d = state_q;
    px_d    = px_q;
    py_d    = py_q;
    r_d     = r_q;
    dx_d    = dx_q;
    dy_d    = dy_q;
    unique case (state_q)
      dwf_pkg::ST_IDLE: begin
        if (accept && (in_i.req_type == dwf_pkg::REQ_QUERY)) begin
          state_d = dwf_pkg::ST_RUN;
          px_d    = in_i.pos_x;
          py_d    = in_i.pos_y;
          r_d     = r_clamp;
          dx_d    = -r_in_s;
          dy_d    = -r_in_s;
        end
      end
      dwf_pkg::ST_RUN: begin
        if (rd_o.issue) begin
          if (dy_q == r_s) begin
            dy_d = -r_s;
            dx_d = dx_q + DELTA_W'(1);
            if (at_last) begin
              state_d = dwf_pkg::ST_IDLE;
            end
          end else begin
            dy_d = dy_q + DELTA_W'(1);
          end
        end
      end
      default: state_d = dwf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dwf_pkg::ST_IDLE;
      dx_q    <= '0;
      dy_q    <= '0;
    end else begin
      state_q <= state_d;
      dx_q    <= dx_d;
      dy_q    <= dy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q <= px_d;
    py_q <= py_d;
    r_q  <= r_d;
  end

  `DWF_ASSERT(a_write_only_idle, clk_i, rst_ni, we_o |-> (state_q == dwf_pkg::ST_IDLE), "store write while a window is running")
  `DWF_ASSERT(a_last_ends_walk, clk_i, rst_ni, (rd_o.issue && rd_o.tag.last) |=> (state_q == dwf_pkg::ST_IDLE), "window walk did not end after its last cell")
  `DWF_ASSERT(a_offsets_in_window, clk_i, rst_ni, run |-> ((dx_q <= r_s) && (dy_q <= r_s) && (dx_q >= -r_s) && (dy_q >= -r_s)), "window offset outside the radius")

endmodule

`default_nettype wire

FILE: sv/dwf_out.sv
// read tag stage and output register of the window results
`default_nettype none

module dwf_out #(
  parameter int unsigned VALUE_BITS = dwf_pkg::DEF_VALUE_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire dwf_pkg::rd_req_t      rd_i,
  input  wire logic [VALUE_BITS-1:0] rdata_i,
  output logic                       issue_ok_o,
  dwf_out_if.source                  out_o
);

  localparam int unsigned OUT_W = dwf_pkg::OUT_W;

  logic              pv_q, pv_d;
  dwf_pkg::rd_tag_t  ptag_q, ptag_d;
  logic              ov_q, ov_d;
  logic [OUT_W-1:0]  oval_q, oval_d;
  logic              olast_q, olast_d;
  logic              p_move;

  // tag stage moves on when the output register is free or being taken
  assign p_move     = pv_q && (!ov_q || out_o.ready);
  assign issue_ok_o = !pv_q || p_move;

  always_comb begin
    pv_d    = pv_q;
    ptag_d  = ptag_q;
    ov_d    = ov_q;
    oval_d  = oval_q;
    olast_d = olast_q;
    if (rd_i.issue) begin
      pv_d   = 1'b1;
      ptag_d = rd_i.tag;
    end else if (p_move) begin
      pv_d = 1'b0;
    end
    if (p_move) begin
      ov_d    = 1'b1;
      oval_d  = ptag_q.off ? dwf_pkg::OFF_VALUE : OUT_W'(rdata_i);
      olast_d = ptag_q.last;
    end else if (out_o.ready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      pv_q <= pv_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptag_q  <= ptag_d;
    oval_q  <= oval_d;
    olast_q <= olast_d;
  end

  assign out_o.valid        = ov_q;
  assign out_o.window_value = $signed(oval_q);
  assign out_o.is_last      = olast_q;

endmodule

`default_nettype wire

FILE: sv/diamond_window_fetch_top.sv
// window fetch top level: register bank, sequencer, grid store and result stage
// a write request gives no result; a query holds the input while it walks all
// (2r+1)^2 cells of the square around its position, r the radius clamped to MAX_RADIUS
// one store read per window cell; the first result passes the read and tag stage, then the output register
// output back-pressure stalls the walk; a new request is taken once the walk is done
// reset: grid size back to 64 by 64, pipeline empty; store contents left undefined
`default_nettype none

module diamond_window_fetch_top #(
  parameter int unsigned MAX_COLS   = dwf_pkg::DEF_MAX_COLS,
  parameter int unsigned MAX_ROWS   = dwf_pkg::DEF_MAX_ROWS,
  parameter int unsigned VALUE_BITS = dwf_pkg::DEF_VALUE_BITS,
  parameter int unsigned MAX_RADIUS = dwf_pkg::DEF_MAX_RADIUS
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dwf_in_if.sink     in_i,
  dwf_out_if.source  out_o,
  dwf_cfg_if.sink    cfg_i
);

  localparam int unsigned CB    = $clog2(MAX_COLS);
  localparam int unsigned RB    = $clog2(MAX_ROWS);
  localparam int unsigned AW    = CB + RB;
  // column-major store: column in the upper address bits, row in the lower
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned CMP_W = dwf_pkg::CMP_W;
  localparam int unsigned SIZE_W = dwf_pkg::SIZE_W;

  logic [SIZE_W-1:0]       width_q, width_d;
  logic [SIZE_W-1:0]       height_q, height_d;
  logic signed [CMP_W-1:0] cols_lim, rows_lim;

  dwf_pkg::rd_req_t        rd_req;
  logic                    issue_ok;
  logic                    we;
  logic [AW-1:0]           addr;
  logic [VALUE_BITS-1:0]   wdata;
  logic [VALUE_BITS-1:0]   rdata;

  // register writes are always taken at once
  assign cfg_i.ready = 1'b1;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        dwf_pkg::CFG_GRID_WIDTH:  width_d  = SIZE_W'(cfg_i.data);
        dwf_pkg::CFG_GRID_HEIGHT: height_d = SIZE_W'(cfg_i.data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= dwf_pkg::SIZE_RESET;
      height_q <= dwf_pkg::SIZE_RESET;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // grid size in use, never beyond what the store holds
  assign cols_lim = (int'(width_q) > int'(MAX_COLS)) ? CMP_W'(MAX_COLS) : CMP_W'(width_q);
  assign rows_lim = (int'(height_q) > int'(MAX_ROWS)) ? CMP_W'(MAX_ROWS) : CMP_W'(height_q);

  // sequencer: takes requests, writes cells, walks the window one cell a cycle unless the result stage stalls it
  dwf_seq #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .VALUE_BITS (VALUE_BITS),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cols_i     (cols_lim),
    .rows_i     (rows_lim),
    .issue_ok_i (issue_ok),
    .rd_o       (rd_req),
    .we_o       (we),
    .addr_o     (addr),
    .wdata_o    (wdata)
  );

  // grid store, written and read through the shared address
  dwf_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_grid_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (addr),
    .wdata_i (wdata),
    .re_i    (rd_req.issue),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  // read tag stage and output register, decoupling the walk from the sink
  dwf_out #(
    .VALUE_BITS (VALUE_BITS)
  ) u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_i       (rd_req),
    .rdata_i    (rdata),
    .issue_ok_o (issue_ok),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

FILE: tb/tb.sv
// self-checking testbench of the window fetch block: scoreboard, request and result drivers
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dwf_pkg::*;

  // geometry of the store as built
  localparam int GRID_COLS  = int'(DEF_MAX_COLS);
  localparam int GRID_ROWS  = int'(DEF_MAX_ROWS);
  localparam int WIN_RADIUS = int'(DEF_MAX_RADIUS);

  // register indexes that map to no register
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

  // run shape
  localparam int ITEM_TARGET    = 310;
  localparam int CALM_ITEMS     = 40;
  localparam int PHASE_ITEMS    = 45;
  localparam int HOLD_AT        = 120;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 64;
  localparam int CLK_PERIOD     = 10;
  localparam int TIMEOUT_CYCLES = 1_000_000;

  typedef struct packed {
    req_e              kind;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [CELL_W-1:0] cell_value;
    logic [RAD_W-1:0]  radius;
  } window_req_t;

  // predicts every window cell and checks the results against it in order
  class window_scoreboard;
    typedef struct packed {
      logic [OUT_W-1:0] value;
      logic             last;
    } cell_result_t;

    logic [CELL_W-1:0] grid_cells   [GRID_COLS*GRID_ROWS];
    bit                cell_written [GRID_COLS*GRID_ROWS];
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    cell_result_t      expected_cells [$];
    int unsigned       fails;

    function new();
      width_reg  = SIZE_RESET;
      height_reg = SIZE_RESET;
      fails      = 0;
    endfunction

    // sizes above the store act as the store size, zero means no cell at all
    function bit on_grid(int cx, int cy);
      int cols, rows;
      cols = (int'(width_reg) > GRID_COLS) ? GRID_COLS : int'(width_reg);
      rows = (int'(height_reg) > GRID_ROWS) ? GRID_ROWS : int'(height_reg);
      return cx >= 0 && cx < cols && cy >= 0 && cy < rows;
    endfunction

    function int reach(int dx, int dy);
      return (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_GRID_WIDTH) width_reg = data;
      else if (idx == CFG_GRID_HEIGHT) height_reg = data;
    endfunction

    // cells a query would read that hold nothing yet
    function void list_unwritten(int px, int py, int radius, output int missing[$]);
      int cx, cy;
      missing = {};
      for (int dx = -radius; dx <= radius; dx++)
        for (int dy = -radius; dy <= radius; dy++) begin
          cx = px + dx;
          cy = py + dy;
          if (on_grid(cx, cy) && reach(dx, dy) <= radius &&
              !cell_written[cx*GRID_ROWS + cy])
            missing = {missing, cx*GRID_ROWS + cy};
        end
    endfunction

    function void accept_request(window_req_t rq);
      int r, side, n, cx, cy;
      cell_result_t res;
      if (rq.kind == REQ_WRITE) begin
        if (on_grid(int'(rq.pos_x), int'(rq.pos_y))) begin
          grid_cells[int'(rq.pos_x)*GRID_ROWS + int'(rq.pos_y)]   = rq.cell_value;
          cell_written[int'(rq.pos_x)*GRID_ROWS + int'(rq.pos_y)] = 1'b1;
        end
        return;
      end
      r    = (int'(rq.radius) > WIN_RADIUS) ? WIN_RADIUS : int'(rq.radius);
      side = 2*r + 1;
      n    = 0;
      for (int dx = -r; dx <= r; dx++)
        for (int dy = -r; dy <= r; dy++) begin
          cx        = int'(rq.pos_x) + dx;
          cy        = int'(rq.pos_y) + dy;
          res.value = OFF_VALUE;
          if (on_grid(cx, cy) && reach(dx, dy) <= r)
            res.value = OUT_W'(grid_cells[cx*GRID_ROWS + cy]);
          res.last = (n == side*side - 1);
          expected_cells = {expected_cells, res};
          n++;
        end
    endfunction

    function void check_cell(logic [OUT_W-1:0] value, logic last);
      cell_result_t want;
      if (expected_cells.size() == 0) begin
        $display("%0t: result with none expected, value %0d last %0b",
                 $time, $signed(value), last);
        fails++;
        return;
      end
      want = expected_cells.pop_front();
      if (value !== want.value) begin
        $display("%0t: window value mismatch, expected %0d actual %0d",
                 $time, $signed(want.value), $signed(value));
        fails++;
      end
      if (last !== want.last) begin
        $display("%0t: last flag mismatch, expected %0b actual %0b",
                 $time, want.last, last);
        fails++;
      end
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  dwf_in_if  in_if();
  dwf_out_if out_if();
  dwf_cfg_if cfg_if();

  diamond_window_fetch_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  window_scoreboard sb = new();

  int items_sent = 0;
  bit calm       = 1'b0;   // final stretch: no idling on either side
  bit hold_sink  = 1'b0;   // asks the result side for one long hold-off
  bit hold_done  = 1'b0;
  bit src_busy   = 1'b1;   // sender idling switched on or off in stretches

  always begin
    #(CLK_PERIOD/2) clk_i = 1'b1;
    #(CLK_PERIOD/2) clk_i = 1'b0;
  end

  // values biased towards the extremes
  function automatic logic [CELL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return CELL_W'($urandom_range(0, 255));
    endcase
  endfunction

  // offer one request and hold it until taken, then maybe leave a gap
  task automatic send_req(req_e kind, int px, int py, logic [CELL_W-1:0] value,
                          int radius);
    window_req_t rq;
    int idle;
    rq.kind       = kind;
    rq.pos_x      = POS_W'(px);
    rq.pos_y      = POS_W'(py);
    rq.cell_value = value;
    rq.radius     = RAD_W'(radius);
    in_if.valid      <= 1'b1;
    in_if.req_type   <= rq.kind;
    in_if.pos_x      <= rq.pos_x;
    in_if.pos_y      <= rq.pos_y;
    in_if.cell_value <= rq.cell_value;
    in_if.radius     <= rq.radius;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    sb.accept_request(rq);
    items_sent++;
    if ($urandom_range(0, 15) == 0) src_busy = !src_busy;
    if (!calm && src_busy && $urandom_range(0, 2) == 0) begin
      idle = $urandom_range(1, 14);
      in_if.valid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
  endtask

  // a query is preceded by writes of any cell it would read that is still empty
  task automatic issue_query(int px, int py, int radius);
    int missing[$];
    sb.list_unwritten(px, py, radius, missing);
    foreach (missing[k])
      send_req(REQ_WRITE, missing[k] / GRID_ROWS, missing[k] % GRID_ROWS, pick_value(),
               $urandom_range(0, 3));
    send_req(REQ_QUERY, px, py, CELL_W'($urandom_range(0, 255)), radius);
  endtask

  // let the block run dry before touching its registers or ending
  task automatic wait_idle(int settle);
    in_if.valid <= 1'b0;
    while (sb.expected_cells.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    sb.write_reg(idx, data);
  endtask

  task automatic set_grid(int w, int h, bit with_spare);
    wait_idle(SETTLE_CYCLES);
    write_reg(CFG_GRID_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_GRID_HEIGHT, CFG_DATA_W'(h));
    if (with_spare || $urandom_range(0, 2) == 0)
      write_reg($urandom_range(0, 1) ? CFG_IDX_SPARE_HI : CFG_IDX_SPARE_LO,
                CFG_DATA_W'($urandom_range(0, 127)));
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // random traffic around a hot patch of the grid so that written cells get reused
  task automatic run_phase(int w, int h);
    int hot_x, hot_y, px, py;
    hot_x = (w > 64) ? $urandom_range(0, 56) : (w >= 8 ? $urandom_range(0, w - 8) : 0);
    hot_y = (h > 64) ? $urandom_range(0, 56) : (h >= 8 ? $urandom_range(0, h - 8) : 0);
    for (int n = 0; n < PHASE_ITEMS && items_sent < ITEM_TARGET; n++) begin
      if (items_sent >= ITEM_TARGET - CALM_ITEMS) calm = 1'b1;
      if (!hold_done && items_sent >= HOLD_AT) begin
        // result side goes quiet while requests keep coming
        hold_sink = 1'b1;
        hold_done = 1'b1;
      end
      if ($urandom_range(0, 3) == 0) begin
        px = $urandom_range(0, 63);
        py = $urandom_range(0, 63);
      end else begin
        px = hot_x + $urandom_range(0, 7);
        py = hot_y + $urandom_range(0, 7);
      end
      if ($urandom_range(0, 99) < 55)
        issue_query(px, py, $urandom_range(0, 3));
      else
        send_req(REQ_WRITE, px, py, pick_value(), $urandom_range(0, 3));
    end
  endtask

  // result side: checks every taken result and stalls in random bursts
  initial begin : result_sink
    int gap_left, hold_left;
    bit busy;
    gap_left  = 0;
    hold_left = 0;
    busy      = 1'b1;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1)
        sb.check_cell(out_if.window_value, out_if.is_last);
      if (hold_sink) begin
        hold_sink = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if ($urandom_range(0, 63) == 0) busy = !busy;
      if (calm) begin
        hold_left = 0;
        gap_left  = 0;
        out_if.ready <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        out_if.ready <= 1'b0;
      end else if (busy && $urandom_range(0, 5) == 0) begin
        // starts a stalled burst that goes on while gap_left runs down
        gap_left = $urandom_range(0, 13);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int w, h;
    in_if.valid      <= 1'b0;
    in_if.req_type   <= REQ_WRITE;
    in_if.pos_x      <= '0;
    in_if.pos_y      <= '0;
    in_if.cell_value <= '0;
    in_if.radius     <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= CFG_GRID_WIDTH;
    cfg_if.data      <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corner at the origin, full-size grid from reset, extreme values
    send_req(REQ_WRITE, 0, 0, 8'hFF, 0);
    send_req(REQ_WRITE, 1, 0, 8'h00, 0);
    send_req(REQ_WRITE, 0, 1, 8'h01, 3);
    issue_query(0, 0, 0);
    issue_query(0, 0, 1);
    issue_query(0, 0, 2);
    // far corner
    send_req(REQ_WRITE, 63, 63, 8'hAA, 1);
    send_req(REQ_WRITE, 62, 63, 8'h55, 2);
    send_req(REQ_WRITE, 63, 62, 8'h80, 0);
    issue_query(63, 63, 1);
    // empty grid: everything reads as off grid, writes are dropped
    set_grid(0, 64, 1'b1);
    issue_query(5, 5, 2);
    send_req(REQ_WRITE, 3, 3, 8'h7F, 0);
    // sizes beyond the store behave as the store size
    set_grid(127, 100, 1'b0);
    issue_query(63, 63, 1);
    // single cell grid, writes just outside it are dropped, widest radius
    set_grid(1, 1, 1'b1);
    send_req(REQ_WRITE, 0, 1, 8'h33, 0);
    send_req(REQ_WRITE, 1, 0, 8'h44, 0);
    issue_query(0, 0, 3);

    // random phases, each after a new grid size is set
    for (int p = 0; items_sent < ITEM_TARGET; p++) begin
      case (p % 7)
        0: begin w = 64; h = 64; end
        1: begin w = 1; h = 64; end
        2: begin w = 64; h = 1; end
        3: begin w = $urandom_range(1, 64); h = $urandom_range(1, 64); end
        4: begin w = 127; h = $urandom_range(65, 127); end
        5: begin w = $urandom_range(0, 127); h = 0; end
        default: begin w = $urandom_range(2, 10); h = $urandom_range(2, 10); end
      endcase
      set_grid(w, h, 1'b0);
      run_phase(w, h);
    end

    wait_idle(DRAIN_CYCLES);
    if (sb.fails == 0 && sb.expected_cells.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // hard stop in case the block hangs
  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("TB_ERROR");
    $finish;
  end

endmodule
